@@ rtl/udec_pkg.sv @@
// ----------------------------------------------------------------------------
// udec_pkg
// Shared types and constants for the utf-8 stream decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package udec_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned CodeW      = 21;
  localparam int unsigned BitsW      = 7;
  localparam int unsigned PendW      = 2;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned OutDataW   = 24;

  localparam logic [ByteW-1:0] ASCII_MAX  = 8'h7f;
  localparam logic [ByteW-1:0] LEAD2_MIN  = 8'hc2;
  localparam logic [ByteW-1:0] LEAD2_MAX  = 8'hdf;
  localparam logic [ByteW-1:0] LEAD3_MAX  = 8'hef;
  localparam logic [ByteW-1:0] LEAD4_MAX  = 8'hf4;
  localparam logic [ByteW-1:0] CONT_MIN   = 8'h80;
  localparam logic [ByteW-1:0] CONT_LIMIT = 8'hc0;

  // byte class decided by the front end
  typedef enum logic [2:0] {
    KIND_ASCII,
    KIND_LEAD2,
    KIND_LEAD3,
    KIND_LEAD4,
    KIND_CONT,
    KIND_BAD
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [BitsW-1:0] bits;
    logic             eos;
  } item_t;

  typedef struct packed {
    logic             char_valid;
    logic [CodeW-1:0] code_point;
    logic             string_end;
    logic             string_ok;
  } result_t;

endpackage

@@ rtl/udec_front.sv @@
// ----------------------------------------------------------------------------
// udec_front
// Classifies each incoming byte and pushes it into the request queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module udec_front import udec_pkg::*; (
  input  logic [ByteW-1:0] data_byte_i,
  input  logic             end_of_string_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             q_full_i,
  output logic             q_push_o,
  output item_t            q_item_o
);

  kind_e kind;

  always_comb begin
    if (data_byte_i <= ASCII_MAX) begin
      kind = KIND_ASCII;
    end else if (data_byte_i < CONT_LIMIT) begin
      kind = KIND_CONT;
    end else if (data_byte_i >= LEAD2_MIN && data_byte_i <= LEAD2_MAX) begin
      kind = KIND_LEAD2;
    end else if (data_byte_i > LEAD2_MAX && data_byte_i <= LEAD3_MAX) begin
      kind = KIND_LEAD3;
    end else if (data_byte_i > LEAD3_MAX && data_byte_i <= LEAD4_MAX) begin
      kind = KIND_LEAD4;
    end else begin
      kind = KIND_BAD;
    end
  end

  assign in_ready_o    = !q_full_i;
  assign q_push_o      = in_valid_i && !q_full_i;
  assign q_item_o.kind = kind;
  assign q_item_o.bits = data_byte_i[BitsW-1:0];
  assign q_item_o.eos  = end_of_string_i;

endmodule

@@ rtl/udec_queue.sv @@
// ----------------------------------------------------------------------------
// udec_queue
// Short request queue between the classifier and the decode stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module udec_queue import udec_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output item_t item_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(QueueDepth);
  localparam logic [PtrW-1:0] LastPtr  = PtrW'(QueueDepth - 1);

  item_t           mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == DepthCnt);
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthCnt) else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0) else $error("pop from empty queue");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count did not advance on push");

endmodule

@@ rtl/udec_back.sv @@
// ----------------------------------------------------------------------------
// udec_back
// Sequence decode state and the output register for results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module udec_back import udec_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_empty_i,
  input  item_t   q_item_i,
  output logic    q_pop_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_result_o
);

  logic [PendW-1:0] pend_q, pend_d;
  logic [CodeW-1:0] part_q, part_d;
  logic             failed_q, failed_d;
  logic             out_valid_q, out_valid_d;
  result_t          out_q, out_d;

  logic             got_char;
  logic [CodeW-1:0] cp;
  logic [CodeW-1:0] shifted;
  logic             eos;

  // the output slot frees up in the same cycle it is taken
  assign q_pop_o = !q_empty_i && (!out_valid_q || out_ready_i);
  assign eos     = q_item_i.eos;
  assign shifted = {part_q[CodeW-7:0], q_item_i.bits[5:0]};

  always_comb begin
    pend_d      = pend_q;
    part_d      = part_q;
    failed_d    = failed_q;
    got_char    = 1'b0;
    cp          = '0;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (q_pop_o) begin
      if (!failed_q) begin
        if (pend_q == '0) begin
          unique case (q_item_i.kind)
            KIND_ASCII: begin
              got_char = 1'b1;
              cp       = CodeW'(q_item_i.bits);
            end
            KIND_LEAD2: begin
              part_d = CodeW'(q_item_i.bits[4:0]);
              pend_d = 2'd1;
            end
            KIND_LEAD3: begin
              part_d = CodeW'(q_item_i.bits[3:0]);
              pend_d = 2'd2;
            end
            KIND_LEAD4: begin
              part_d = CodeW'(q_item_i.bits[2:0]);
              pend_d = 2'd3;
            end
            default: begin
              failed_d = 1'b1;
            end
          endcase
        end else if (q_item_i.kind == KIND_CONT) begin
          pend_d = pend_q - 1'b1;
          part_d = shifted;
          if (pend_q == 2'd1) begin
            got_char = 1'b1;
            cp       = shifted;
            part_d   = '0;
          end
        end else begin
          failed_d = 1'b1;
          pend_d   = '0;
          part_d   = '0;
        end
      end

      // truncated sequence at end of string
      if (eos && pend_d != '0) begin
        failed_d = 1'b1;
      end

      if (got_char || eos) begin
        out_valid_d      = 1'b1;
        out_d.char_valid = got_char;
        out_d.code_point = cp;
        out_d.string_end = eos;
        out_d.string_ok  = eos && !failed_d;
      end

      if (eos) begin
        pend_d   = '0;
        part_d   = '0;
        failed_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      part_q      <= '0;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      part_q      <= part_d;
      failed_q    <= failed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_result_o = out_q;

  a_fail_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q |-> pend_q == '0) else $error("open sequence in failed string");

  a_eos_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && eos) |=> (pend_q == '0 && !failed_q && part_q == '0))
    else $error("state not cleared after end of string");

  a_eos_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && eos) |=> (out_valid_q && out_q.string_end))
    else $error("end of string gave no result");

endmodule

@@ rtl/utf8_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Decodes a utf-8 byte stream into code points with a pass/fail per string.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                        tuser        tlast
//  s_axis   in   [7:0] data_byte              -            end_of_string
//  m_axis   out  [20:0] code_point,           char_valid   string_end
//                [21] string_ok, [23:22] zero
//
//  one byte per cycle sustained while m_axis_tready holds; an input request reaches
//  the result through a queue slot, then the decode stage into the output register
//  the decode stage pops a queued byte whenever the output register is free
//  or being taken, so back pressure fills the two-entry queue before tready drops
//  bytes that give no result (lead bytes, inner continuations) pass silently
//  reset clears the queue, the decode state and the output valid
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_stream_decoder import udec_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [ByteW-1:0]    s_axis_tdata_i,   // [7:0] data_byte
  input  logic                s_axis_tlast_i,   // end_of_string
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,   // [20:0] code_point, [21] string_ok
  output logic                m_axis_tuser_o,   // [0] char_valid
  output logic                m_axis_tlast_o    // string_end
);

  logic    q_push;
  logic    q_pop;
  logic    q_full;
  logic    q_empty;
  item_t   q_in;
  item_t   q_out;
  result_t res;

  udec_front u_front (
    .data_byte_i     (s_axis_tdata_i),
    .end_of_string_i (s_axis_tlast_i),
    .in_valid_i      (s_axis_tvalid_i),
    .in_ready_o      (s_axis_tready_o),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_item_o        (q_in)
  );

  udec_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .item_o  (q_out)
  );

  udec_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_item_i     (q_out),
    .q_pop_o      (q_pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_result_o (res)
  );

  assign m_axis_tdata_o = {{(OutDataW - CodeW - 1){1'b0}}, res.string_ok, res.code_point};
  assign m_axis_tuser_o = res.char_valid;
  assign m_axis_tlast_o = res.string_end;

endmodule
